// ===== design/hcd_pkg.sv =====
// hcd_pkg: shared types and constants of the hessian corner detector
// word layouts for the pixel and corner channels, register indexes, reset values
// no dependencies
`default_nettype none

package hcd_pkg;

  // fixed field widths of the channel words
  localparam int PIX_FIELD_W = 16;
  localparam int ROW_W       = 12;
  localparam int COL_W       = 10;
  localparam int IDX_W       = 16;

  // configuration port
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 2;
  localparam int WIDTH_W     = 11;
  localparam int HEIGHT_W    = 12;
  localparam int RATIO_W     = 8;
  localparam int LIMIT_W     = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CURVATURE_RATIO = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_CORNERS     = 2'd3;

  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd200;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 12'd200;
  localparam logic [RATIO_W-1:0]  RATIO_RESET  = 8'd10;
  localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 16'd1000;

  // defaults of the top-level parameters
  localparam int MAX_WIDTH_DEFAULT  = 1024;
  localparam int PIXEL_BITS_DEFAULT = 16;

  // pixel channel word
  typedef struct packed {
    logic [PIX_FIELD_W-1:0] pixel;
    logic                   frame_start;
  } pix_word_t;

  // corner channel word
  typedef struct packed {
    logic [ROW_W-1:0] corner_row;
    logic [COL_W-1:0] corner_col;
    logic [IDX_W-1:0] corner_index;
  } corner_word_t;

endpackage

`default_nettype wire

// ===== design/hessian_corner_detector.sv =====
// hessian_corner_detector: streaming 3x3 hessian curvature-ratio corner test
// depends on hcd_pkg and hcd_ram (both line stores packed in one ram word)
//
//  channel  | signals                           | direction | word
//  pixel    | pix_valid, pix_ready, pix_data    | in        | hcd_pkg::pix_word_t
//  corner   | corner_valid, corner_ready, ...   | out       | hcd_pkg::corner_word_t
//  config   | cfg_we, cfg_index, cfg_data       | in        | register write, no wait
//
// A pixel word on the border or once the corner limit is hit passes S_IDLE and
// S_READ only; for the curvature test it also passes S_MUL, S_SCALE, S_PROD, S_TEST
// (ram read, differences, products, scaling, final product, compare), as the chain
// of multipliers needs; the next pixel is taken only back in S_IDLE. After reset a
// clearing pass writes zeros through all MAX_WIDTH ram words, with pix_ready low.
// A hit with a full corner register not taken holds S_TEST; the pixel side waits.
`default_nettype none

module hessian_corner_detector #(
  parameter int MAX_WIDTH  = hcd_pkg::MAX_WIDTH_DEFAULT,
  parameter int PIXEL_BITS = hcd_pkg::PIXEL_BITS_DEFAULT
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            pix_valid,
  output logic                                 pix_ready,
  input  wire hcd_pkg::pix_word_t              pix_data,
  output logic                                 corner_valid,
  input  wire logic                            corner_ready,
  output hcd_pkg::corner_word_t                corner_data,
  input  wire logic                            cfg_we,
  input  wire logic [hcd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [hcd_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int PB    = PIXEL_BITS;
  localparam int AW    = $clog2(MAX_WIDTH);
  localparam int XW    = $clog2(MAX_WIDTH + 1);
  localparam int CFW   = (XW > hcd_pkg::WIDTH_W) ? XW : hcd_pkg::WIDTH_W;
  localparam int CXW   = (AW > hcd_pkg::COL_W) ? AW : hcd_pkg::COL_W;
  localparam int PXW   = (PB > hcd_pkg::PIX_FIELD_W) ? PB : hcd_pkg::PIX_FIELD_W;
  localparam int RW_   = hcd_pkg::ROW_W;
  localparam int DW    = PB + 3;
  localparam int TW    = PB + 4;
  localparam int DETW  = 2 * DW + 5;
  localparam int TSQW  = 2 * TW + 4;
  localparam int LW    = TSQW + hcd_pkg::RATIO_W;
  localparam int R1W   = hcd_pkg::RATIO_W + 1;
  localparam int RSQW  = 2 * R1W;
  localparam int RHW   = DETW - 1 + RSQW;
  localparam int CMPW  = (LW > RHW) ? LW : RHW;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_SCALE = 3'd4;
  localparam logic [2:0] S_PROD  = 3'd5;
  localparam logic [2:0] S_TEST  = 3'd6;

  // configuration registers
  logic [hcd_pkg::WIDTH_W-1:0]  image_width;
  logic [hcd_pkg::HEIGHT_W-1:0] image_height;
  logic [hcd_pkg::RATIO_W-1:0]  curvature_ratio;
  logic [hcd_pkg::LIMIT_W-1:0]  max_corners;

  // control state
  logic [2:0]                   state;
  logic [AW-1:0]                clr_addr;
  logic [AW-1:0]                col_cnt;
  logic [RW_-1:0]               row_cnt;
  logic [hcd_pkg::IDX_W-1:0]    corners_found;

  // item registers
  logic [AW-1:0]                x_reg;
  logic [RW_-1:0]               y_reg;
  logic [PB-1:0]                pix_reg;
  logic                         elig_reg;
  logic                         wrap_reg;
  logic [PB-1:0]                win [6];

  // arithmetic registers
  logic signed [DW-1:0]         dxx_reg, dyy_reg, dxy_reg;
  logic signed [TW-1:0]         tr_reg;
  logic signed [2*DW-1:0]       pxy_reg, pdd_reg;
  logic signed [2*TW-1:0]       tsq_reg;
  logic [RSQW-1:0]              r1sq_reg;
  logic signed [DETW-1:0]       det_reg;
  logic [LW-1:0]                lhs_reg;
  logic [RHW-1:0]               rhs_reg;
  logic                         det_pos_reg;

  // ram ports
  logic                         ram_we;
  logic [AW-1:0]                ram_waddr, ram_raddr;
  logic [2*PB-1:0]              ram_wdata, ram_rdata;

  // combinational signals
  logic                         accept;
  logic [XW-1:0]                w_eff;
  logic [CFW-1:0]               w_cfg;
  logic [RW_-1:0]               h_eff;
  logic [AW-1:0]                col0, col1, col_n;
  logic [RW_:0]                 row1, row_inc;
  logic [RW_-1:0]               row0, row_n, y_cur;
  logic [hcd_pkg::IDX_W-1:0]    found0, found1;
  logic [XW-1:0]                x_inc;
  logic                         wrap_n, elig_n;
  logic [PXW-1:0]               pix_ext;
  logic [PB-1:0]                pix_in;
  logic [PB-1:0]                top, mid;
  logic signed [DW-1:0]         dxx_c, dyy_c, dxy_c;
  logic [TSQW-1:0]              tsq16;
  logic [DETW-2:0]              det_mag;
  logic                         hit, out_free;
  logic [CXW-1:0]               xm1;

  assign accept    = pix_valid && pix_ready;
  assign pix_ready = (state == S_IDLE);
  assign out_free  = !corner_valid || corner_ready;
  assign pix_ext   = PXW'(pix_data.pixel);
  assign pix_in    = pix_ext[PB-1:0];

  // effective frame size, clamped
  always_comb begin
    w_cfg = CFW'(image_width);
    if (w_cfg < CFW'(3)) begin
      w_eff = XW'(3);
    end else if (w_cfg > CFW'(MAX_WIDTH)) begin
      w_eff = XW'(MAX_WIDTH);
    end else begin
      w_eff = w_cfg[XW-1:0];
    end
    h_eff = (image_height < RW_'(3)) ? RW_'(3) : image_height;
  end

  // position of the incoming pixel and counters after it
  always_comb begin
    col0   = pix_data.frame_start ? '0 : col_cnt;
    row0   = pix_data.frame_start ? '0 : row_cnt;
    found0 = pix_data.frame_start ? '0 : corners_found;
    if (XW'(col0) >= w_eff) begin
      col1 = '0;
      row1 = (RW_+1)'(row0) + (RW_+1)'(1);
    end else begin
      col1 = col0;
      row1 = (RW_+1)'(row0);
    end
    found1 = found0;
    if (row1 >= (RW_+1)'(h_eff)) begin
      row1   = '0;
      col1   = '0;
      found1 = '0;
    end
    y_cur   = row1[RW_-1:0];
    x_inc   = XW'(col1) + XW'(1);
    row_inc = (RW_+1)'(y_cur) + (RW_+1)'(1);
    wrap_n  = 1'b0;
    if (x_inc >= w_eff) begin
      col_n = '0;
      if (row_inc >= (RW_+1)'(h_eff)) begin
        row_n  = '0;
        wrap_n = 1'b1;
      end else begin
        row_n = row_inc[RW_-1:0];
      end
    end else begin
      col_n = x_inc[AW-1:0];
      row_n = y_cur;
    end
    elig_n = (y_cur >= RW_'(2)) && (col1 >= AW'(2)) && (found1 < max_corners);
  end

  // second differences of the window, ram word holds {upper, middle}
  assign top = ram_rdata[2*PB-1:PB];
  assign mid = ram_rdata[PB-1:0];
  always_comb begin
    dxx_c = $signed(DW'(win[1])) + $signed(DW'(mid))
          - ($signed(DW'(win[4])) <<< 1);
    dyy_c = $signed(DW'(win[3])) + $signed(DW'(win[5]))
          - ($signed(DW'(win[4])) <<< 1);
    dxy_c = $signed(DW'(pix_reg)) + $signed(DW'(win[0]))
          - $signed(DW'(win[2])) - $signed(DW'(top));
  end

  // scaled terms and final compare
  assign tsq16   = TSQW'($unsigned(tsq_reg)) << 4;
  assign det_mag = det_reg[DETW-2:0];
  assign hit     = det_pos_reg && (CMPW'(lhs_reg) < CMPW'(rhs_reg));
  assign xm1     = CXW'(x_reg) - CXW'(1);

  // line ram: clearing pass, then write-back in the cycle after the read
  assign ram_we    = (state == S_CLEAR) || (state == S_READ);
  assign ram_waddr = (state == S_CLEAR) ? clr_addr : x_reg;
  assign ram_wdata = (state == S_CLEAR) ? '0 : {mid, pix_reg};
  assign ram_raddr = col1;

  hcd_ram #(
    .WIDTH (2 * PB),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width     <= hcd_pkg::WIDTH_RESET;
      image_height    <= hcd_pkg::HEIGHT_RESET;
      curvature_ratio <= hcd_pkg::RATIO_RESET;
      max_corners     <= hcd_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        hcd_pkg::REG_IMAGE_WIDTH:     image_width     <= cfg_data[hcd_pkg::WIDTH_W-1:0];
        hcd_pkg::REG_IMAGE_HEIGHT:    image_height    <= cfg_data[hcd_pkg::HEIGHT_W-1:0];
        hcd_pkg::REG_CURVATURE_RATIO: curvature_ratio <= cfg_data[hcd_pkg::RATIO_W-1:0];
        hcd_pkg::REG_MAX_CORNERS:     max_corners     <= cfg_data[hcd_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer, counters, window and corner register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_addr      <= '0;
      col_cnt       <= '0;
      row_cnt       <= '0;
      corners_found <= '0;
      corner_valid  <= 1'b0;
      for (int i = 0; i < 6; i++) begin
        win[i] <= '0;
      end
    end else begin
      // drop the word once taken, unless the test stage refills it now
      if (corner_valid && corner_ready && !(state == S_TEST && hit)) begin
        corner_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(MAX_WIDTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            x_reg         <= col1;
            y_reg         <= y_cur;
            pix_reg       <= pix_in;
            elig_reg      <= elig_n;
            wrap_reg      <= wrap_n;
            col_cnt       <= col_n;
            row_cnt       <= row_n;
            corners_found <= found1;
            state         <= S_READ;
          end
        end
        S_READ: begin
          win[0]  <= win[3];
          win[1]  <= win[4];
          win[2]  <= win[5];
          win[3]  <= top;
          win[4]  <= mid;
          win[5]  <= pix_reg;
          dxx_reg <= dxx_c;
          dyy_reg <= dyy_c;
          dxy_reg <= dxy_c;
          tr_reg  <= TW'(dxx_c) + TW'(dyy_c);
          if (elig_reg) begin
            state <= S_MUL;
          end else begin
            if (wrap_reg) begin
              corners_found <= '0;
            end
            state <= S_IDLE;
          end
        end
        S_MUL: begin
          pxy_reg  <= (2*DW)'(dxx_reg) * (2*DW)'(dyy_reg);
          pdd_reg  <= (2*DW)'(dxy_reg) * (2*DW)'(dxy_reg);
          tsq_reg  <= (2*TW)'(tr_reg) * (2*TW)'(tr_reg);
          r1sq_reg <= RSQW'(R1W'(curvature_ratio) + R1W'(1))
                    * RSQW'(R1W'(curvature_ratio) + R1W'(1));
          state    <= S_SCALE;
        end
        S_SCALE: begin
          det_reg <= (DETW'(pxy_reg) <<< 4) - DETW'(pdd_reg);
          lhs_reg <= LW'(tsq16) * LW'(curvature_ratio);
          state   <= S_PROD;
        end
        S_PROD: begin
          det_pos_reg <= (det_reg > DETW'(0));
          rhs_reg     <= RHW'(det_mag) * RHW'(r1sq_reg);
          state       <= S_TEST;
        end
        S_TEST: begin
          if (!hit || out_free) begin
            if (hit) begin
              corner_valid             <= 1'b1;
              corner_data.corner_row   <= y_reg - RW_'(1);
              corner_data.corner_col   <= xm1[hcd_pkg::COL_W-1:0];
              corner_data.corner_index <= corners_found;
            end
            if (wrap_reg) begin
              corners_found <= '0;
            end else if (hit) begin
              corners_found <= corners_found + hcd_pkg::IDX_W'(1);
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // the ram write-back always comes in the cycle after an accepted pixel
  assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> $past(accept))
    else $error("line ram write-back without an accepted pixel");

  // a corner word only appears from the test stage
  assert property (@(posedge clk) disable iff (rst)
    $rose(corner_valid) |-> $past(state == S_TEST))
    else $error("corner word raised outside the test stage");

  // a hit with the corner register blocked holds the test stage
  assert property (@(posedge clk) disable iff (rst)
    (state == S_TEST && hit && corner_valid && !corner_ready) |=> (state == S_TEST))
    else $error("corner lost while the output was stalled");

  // no pixel is taken during the clearing pass
  assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !pix_ready)
    else $error("pixel accepted while clearing the line ram");

  // a counter wrap at frame end leaves the corner count cleared
  assert property (@(posedge clk) disable iff (rst)
    ($past(state) != S_IDLE && state == S_IDLE && $past(wrap_reg)) |-> (corners_found == '0))
    else $error("corner count not cleared at frame end");

endmodule

`default_nettype wire

// ===== design/hcd_ram.sv =====
// hcd_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module hcd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== tb/hessian_corner_detector_tb.sv =====
// hessian_corner_detector_tb: self-checking bench for the streaming hessian corner detector
// feeds pixel frames, predicts corner words in a scoreboard class, compares them in order
// depends on hcd_pkg and the hessian_corner_detector rtl
module hessian_corner_detector_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD     = 12;
  localparam int RESET_CYCLES   = 11;
  localparam int IDLE_PCT       = 35;
  localparam int RANDOM_ITEMS   = 650;
  localparam int WIDE_COLS      = 300;
  localparam int HOLD_CYCLES    = 250;
  localparam int PIPE_SETTLE    = 20;
  localparam int DRAIN_LIMIT    = 5000;
  localparam int PHASE_CAP      = 400;
  localparam int TIMEOUT_CYCLES = 1000000;

  typedef enum int {
    STYLE_NOISE, STYLE_CHECKER, STYLE_RIPPLE, STYLE_DIM, STYLE_BINARY, STYLE_PEAK
  } pixel_style_t;

  // predicts corner words from accepted pixel words and checks the output against them
  class corner_scoreboard;
    logic [hcd_pkg::PIX_FIELD_W-1:0] upper_row [hcd_pkg::MAX_WIDTH_DEFAULT];
    logic [hcd_pkg::PIX_FIELD_W-1:0] middle_row [hcd_pkg::MAX_WIDTH_DEFAULT];
    // [0..2] column two back (top, mid, bottom), [3..5] column one back
    logic [hcd_pkg::PIX_FIELD_W-1:0] win [6];
    int unsigned row_pos, col_pos, found;
    logic [hcd_pkg::WIDTH_W-1:0]  width_reg;
    logic [hcd_pkg::HEIGHT_W-1:0] height_reg;
    logic [hcd_pkg::RATIO_W-1:0]  ratio_reg;
    logic [hcd_pkg::LIMIT_W-1:0]  limit_reg;
    hcd_pkg::corner_word_t corner_q [$];
    int unsigned mismatches;

    function new();
      foreach (upper_row[i]) begin
        upper_row[i]  = '0;
        middle_row[i] = '0;
      end
      foreach (win[i]) win[i] = '0;
      row_pos    = 0;
      col_pos    = 0;
      found      = 0;
      mismatches = 0;
      width_reg  = hcd_pkg::WIDTH_RESET;
      height_reg = hcd_pkg::HEIGHT_RESET;
      ratio_reg  = hcd_pkg::RATIO_RESET;
      limit_reg  = hcd_pkg::LIMIT_RESET;
    endfunction

    function void write_reg(logic [hcd_pkg::CFG_INDEX_W-1:0] idx,
                            logic [hcd_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        hcd_pkg::REG_IMAGE_WIDTH:     width_reg  = val[hcd_pkg::WIDTH_W-1:0];
        hcd_pkg::REG_IMAGE_HEIGHT:    height_reg = val[hcd_pkg::HEIGHT_W-1:0];
        hcd_pkg::REG_CURVATURE_RATIO: ratio_reg  = val[hcd_pkg::RATIO_W-1:0];
        hcd_pkg::REG_MAX_CORNERS:     limit_reg  = val[hcd_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    endfunction

    // curvature ratio test on a 3x3 neighborhood, row-major from top left, scaled by 16
    function bit hessian_peak(logic [hcd_pkg::PIX_FIELD_W-1:0] nb [9]);
      longint v [9];
      longint dxx, dyy, dxy4, det16, trace, r;
      foreach (v[i]) v[i] = longint'(nb[i]);
      dxx   = v[3] + v[5] - 2 * v[4];
      dyy   = v[1] + v[7] - 2 * v[4];
      dxy4  = v[8] + v[0] - v[6] - v[2];
      det16 = 16 * dxx * dyy - dxy4 * dxy4;
      trace = dxx + dyy;
      r     = longint'(ratio_reg);
      if (det16 <= 0) return 1'b0;
      return (16 * trace * trace * r) < ((r + 1) * (r + 1) * det16);
    endfunction

    // advance the raster position and window by one pixel word
    function void take_pixel(hcd_pkg::pix_word_t word);
      int unsigned wd, ht, x, y;
      logic [hcd_pkg::PIX_FIELD_W-1:0] top, mid;
      logic [hcd_pkg::PIX_FIELD_W-1:0] nb [9];
      hcd_pkg::corner_word_t hit;
      wd = 32'(width_reg);
      if (wd < 3) wd = 3;
      if (wd > hcd_pkg::MAX_WIDTH_DEFAULT) wd = hcd_pkg::MAX_WIDTH_DEFAULT;
      ht = 32'(height_reg);
      if (ht < 3) ht = 3;

      // frame start, and wrap when a bound shrank under the counters
      if (word.frame_start) begin
        row_pos = 0;
        col_pos = 0;
        found   = 0;
      end
      if (col_pos >= wd) begin
        col_pos = 0;
        row_pos++;
      end
      if (row_pos >= ht) begin
        row_pos = 0;
        col_pos = 0;
        found   = 0;
      end
      x   = col_pos;
      y   = row_pos;
      top = upper_row[x];
      mid = middle_row[x];

      // test the pixel one row up and one column back
      nb[0] = win[0]; nb[1] = win[3]; nb[2] = top;
      nb[3] = win[1]; nb[4] = win[4]; nb[5] = mid;
      nb[6] = win[2]; nb[7] = win[5]; nb[8] = word.pixel;
      if (y >= 2 && x >= 2 && found < 32'(limit_reg) && hessian_peak(nb)) begin
        hit.corner_row   = hcd_pkg::ROW_W'(y - 1);
        hit.corner_col   = hcd_pkg::COL_W'(x - 1);
        hit.corner_index = hcd_pkg::IDX_W'(found);
        corner_q.push_back(hit);
        found = (found + 1) & 32'hFFFF;
      end

      // shift window and line stores
      win[0] = win[3];
      win[1] = win[4];
      win[2] = win[5];
      win[3] = top;
      win[4] = mid;
      win[5] = word.pixel;
      upper_row[x]  = mid;
      middle_row[x] = word.pixel;

      col_pos = x + 1;
      if (col_pos >= wd) begin
        col_pos = 0;
        row_pos = y + 1;
        if (row_pos >= ht) begin
          row_pos = 0;
          found   = 0;
        end
      end
    endfunction

    function void check_corner(hcd_pkg::corner_word_t got);
      hcd_pkg::corner_word_t want;
      if (corner_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected corner word: row %0d col %0d index %0d",
                   got.corner_row, got.corner_col, got.corner_index);
        end
        return;
      end
      want = corner_q.pop_front();
      if (got.corner_row !== want.corner_row || got.corner_col !== want.corner_col ||
          got.corner_index !== want.corner_index) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("corner mismatch: expected row %0d col %0d index %0d,",
                   want.corner_row, want.corner_col, want.corner_index,
                   " got row %0d col %0d index %0d",
                   got.corner_row, got.corner_col, got.corner_index);
        end
      end
    endfunction

    function int unsigned pending();
      return corner_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic pix_valid = 1'b0;
  logic pix_ready;
  hcd_pkg::pix_word_t pix_data = '0;
  logic corner_valid;
  logic corner_ready = 1'b0;
  hcd_pkg::corner_word_t corner_data;
  logic cfg_we = 1'b0;
  logic [hcd_pkg::CFG_INDEX_W-1:0] cfg_index = hcd_pkg::REG_IMAGE_WIDTH;
  logic [hcd_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  corner_scoreboard sb;
  bit no_idle = 1'b0;
  bit hold_request = 1'b0;

  hessian_corner_detector i_dut (
    .clk          (clk),
    .rst          (rst),
    .pix_valid    (pix_valid),
    .pix_ready    (pix_ready),
    .pix_data     (pix_data),
    .corner_valid (corner_valid),
    .corner_ready (corner_ready),
    .corner_data  (corner_data),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // pixel content for a position within a frame
  function automatic logic [hcd_pkg::PIX_FIELD_W-1:0] pick_pixel(pixel_style_t style,
                                                               int unsigned col,
                                                               int unsigned row);
    bit odd;
    odd = ((col + row) % 2) == 1;
    case (style)
      STYLE_CHECKER: return odd ? 16'hFFFF : 16'h0000;
      STYLE_RIPPLE:  return odd ? 16'($urandom_range(65535, 40000)) : 16'($urandom_range(25000));
      STYLE_DIM:     return 16'($urandom_range(7));
      STYLE_BINARY:  return ($urandom_range(1) == 1) ? 16'hFFFF : 16'h0000;
      STYLE_PEAK:    return (col == 1 && row == 1) ? 16'h0000 : 16'hFFFF;
      default:       return 16'($urandom);
    endcase
  endfunction

  // offer one pixel word, after a random gap, and hold it until taken
  task automatic send_pixel(input hcd_pkg::pix_word_t word);
    bit taken;
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      pix_valid <= 1'b0;
      @(posedge clk);
    end
    pix_valid <= 1'b1;
    pix_data  <= word;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = pix_ready;
      @(posedge clk);
    end
    sb.take_pixel(word);
  endtask

  // frames of wd x ht, or with noisy set, frame starts scattered at random
  task automatic send_stream(input int unsigned wd, input int unsigned ht,
                             input int unsigned count, input pixel_style_t style,
                             input bit noisy);
    hcd_pkg::pix_word_t word;
    int unsigned k;
    for (int unsigned n = 0; n < count; n++) begin
      k = n % (wd * ht);
      word.frame_start = noisy ? ($urandom_range(15) == 0) : (k == 0);
      word.pixel       = pick_pixel(style, k % wd, k / wd);
      send_pixel(word);
    end
  endtask

  // wait for every expected corner, then let the pipeline empty
  task automatic drain_corners();
    int unsigned waited;
    waited = 0;
    pix_valid <= 1'b0;
    while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (PIPE_SETTLE) @(posedge clk);
  endtask

  task automatic write_one(input logic [hcd_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [hcd_pkg::CFG_DATA_W-1:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  task automatic set_regs(input logic [hcd_pkg::CFG_DATA_W-1:0] wv,
                          input logic [hcd_pkg::CFG_DATA_W-1:0] hv,
                          input logic [hcd_pkg::CFG_DATA_W-1:0] rv,
                          input logic [hcd_pkg::CFG_DATA_W-1:0] lv);
    cfg_we <= 1'b1;
    write_one(hcd_pkg::REG_IMAGE_WIDTH, wv);
    write_one(hcd_pkg::REG_IMAGE_HEIGHT, hv);
    write_one(hcd_pkg::REG_CURVATURE_RATIO, rv);
    write_one(hcd_pkg::REG_MAX_CORNERS, lv);
    cfg_we <= 1'b0;
  endtask

  // corner side: random ready, one long hold-off on request
  initial begin : corner_sink
    hcd_pkg::corner_word_t seen;
    bit took;
    int unsigned hold_left;
    hold_left = 0;
    wait (rst == 1'b0);
    forever begin
      @(negedge clk);
      took = corner_valid && corner_ready;
      seen = corner_data;
      @(posedge clk);
      if (took) sb.check_corner(seen);
      if (hold_left != 0) begin
        hold_left--;
        corner_ready <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
        corner_ready <= 1'b0;
      end else begin
        corner_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  initial begin : stimulus
    int unsigned wv, hv, rv, lv, wd, ht, count, sent, sel;
    bit noisy;
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // clamped tiny frame, ratio zero, limit one: single dark peak
    set_regs(16'd2, 16'd1, 16'd0, 16'd1);
    send_stream(3, 3, 9, STYLE_PEAK, 1'b0);
    drain_corners();

    // checkerboard with two candidates, limit one suppresses the second
    set_regs(16'd4, 16'd3, 16'd255, 16'd1);
    send_stream(4, 3, 12, STYLE_CHECKER, 1'b0);
    drain_corners();

    // dense corners while the corner side holds off
    set_regs(16'd5, 16'd5, 16'd10, 16'd65535);
    hold_request = 1'b1;
    send_stream(5, 5, 75, STYLE_CHECKER, 1'b0);
    sent = 75;

    // random phases, registers rewritten between them, often mid-frame
    while (sent < RANDOM_ITEMS) begin
      drain_corners();
      sel = $urandom_range(99);
      if (sel < 8) wv = $urandom_range(2);
      else if (sel < 12) wv = $urandom_range(2047, 1024);
      else wv = $urandom_range(12, 3);
      sel = $urandom_range(99);
      if (sel < 8) hv = $urandom_range(2);
      else if (sel < 12) hv = 4095;
      else hv = $urandom_range(8, 3);
      sel = $urandom_range(99);
      if (sel < 10) rv = 0;
      else if (sel < 15) rv = 1;
      else if (sel < 25) rv = 255;
      else if (sel < 40) rv = $urandom_range(255);
      else rv = $urandom_range(20, 2);
      sel = $urandom_range(99);
      if (sel < 10) lv = 0;
      else if (sel < 25) lv = $urandom_range(3, 1);
      else if (sel < 40) lv = 65535;
      else lv = $urandom_range(1000, 4);
      set_regs(16'(wv), 16'(hv), 16'(rv), 16'(lv));

      wd = (wv < 3) ? 3 : ((wv > hcd_pkg::MAX_WIDTH_DEFAULT) ? hcd_pkg::MAX_WIDTH_DEFAULT : wv);
      ht = (hv < 3) ? 3 : hv;
      noisy = $urandom_range(99) < 25;
      if (noisy) count = $urandom_range(3 * wd * ht, 1);
      else count = wd * ht * $urandom_range(3, 1);
      if (count > PHASE_CAP) count = PHASE_CAP;
      if (count > RANDOM_ITEMS - sent) count = RANDOM_ITEMS - sent;
      send_stream(wd, ht, count, pixel_style_t'($urandom_range(4)), noisy);
      sent += count;
    end
    drain_corners();

    // one full frame of long rows, no idling on either side
    set_regs(16'(WIDE_COLS), 16'd3, 16'd10, 16'd65535);
    no_idle = 1'b1;
    send_stream(WIDE_COLS, 3, 3 * WIDE_COLS, STYLE_RIPPLE, 1'b0);
    drain_corners();
    no_idle = 1'b0;

    if (sb.pending() != 0) $display("%0d expected corner words never arrived", sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("Some tests failed");
    $finish;
  end

endmodule
